// ===== src/cbws_pkg.sv =====
`default_nettype none

package cbws_pkg;

  localparam int WORD_BITS   = 49;
  localparam int CNT_W       = $clog2(WORD_BITS + 1);
  localparam int POS_W       = $clog2(WORD_BITS);
  localparam int GAP_W       = 16;
  localparam int DLY_W       = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GAP_W-1:0] GAP_RESET   = GAP_W'(110);
  localparam logic [DLY_W-1:0] DELAY_RESET = DLY_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_TICKS    = 1'b0,
    CFG_SAMPLE_DELAY = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] CMD_LED   = 8'h05;
  localparam logic [7:0] CMD_DATE  = 8'ha5;
  localparam logic [7:0] CMD_ZONE0 = 8'h27;
  localparam logic [7:0] CMD_ZONE1 = 8'h2d;
  localparam logic [7:0] CMD_ZONE2 = 8'h34;
  localparam logic [7:0] CMD_ZONE3 = 8'h3e;

  typedef enum logic [2:0] {
    KIND_LED     = 3'd0,
    KIND_DATE    = 3'd1,
    KIND_ZONE0   = 3'd2,
    KIND_ZONE1   = 3'd3,
    KIND_ZONE2   = 3'd4,
    KIND_ZONE3   = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_t;

  // A closed word as it leaves the front end.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     count;
  } cbws_word_t;

  typedef struct packed {
    logic       push;
    cbws_word_t entry;
  } cbws_push_t;

  typedef struct packed {
    logic       valid;
    cbws_word_t entry;
  } cbws_head_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_bits;
    logic [CNT_W-1:0]     bits_received;
    logic [7:0]           command;
    logic [2:0]           kind;
    logic [4:0]           led_flags;
    logic [3:0]           year_tens;
    logic [3:0]           year_ones;
    logic [3:0]           month_value;
    logic [4:0]           day_value;
    logic [4:0]           hour_value;
    logic [5:0]           minute_value;
    logic [7:0]           zone_mask;
  } cbws_result_t;

endpackage

`default_nettype wire

// ===== src/cbws_in_if.sv =====
`default_nettype none

interface cbws_in_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic data_level;

  modport source (output valid, output clock_level, output data_level, input ready);
  modport sink   (input valid, input clock_level, input data_level, output ready);
endinterface

`default_nettype wire

// ===== src/cbws_out_if.sv =====
`default_nettype none

interface cbws_out_if import cbws_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] word_bits;
  logic [CNT_W-1:0]     bits_received;
  logic [7:0]           command;
  logic [2:0]           kind;
  logic [4:0]           led_flags;
  logic [3:0]           year_tens;
  logic [3:0]           year_ones;
  logic [3:0]           month_value;
  logic [4:0]           day_value;
  logic [4:0]           hour_value;
  logic [5:0]           minute_value;
  logic [7:0]           zone_mask;

  modport source (
    output valid, output word_bits, output bits_received, output command, output kind,
    output led_flags, output year_tens, output year_ones, output month_value,
    output day_value, output hour_value, output minute_value, output zone_mask,
    input ready
  );
  modport sink (
    input valid, input word_bits, input bits_received, input command, input kind,
    input led_flags, input year_tens, input year_ones, input month_value,
    input day_value, input hour_value, input minute_value, input zone_mask,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/cbws_front.sv =====
`default_nettype none

module cbws_front import cbws_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cbws_in_if.sink                    in_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  q_full,
  output cbws_push_t                 push
);

  logic [GAP_W-1:0]     gap_r;
  logic [DLY_W-1:0]     sdelay_r;
  logic                 high_seen_r, high_seen_nxt;
  logic [GAP_W-1:0]     elapsed_r, elapsed_nxt;
  logic [DLY_W-1:0]     delay_cnt_r, delay_cnt_nxt;
  logic                 awaiting_r, awaiting_nxt;
  logic [CNT_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;

  logic                 in_fire;
  logic [GAP_W-1:0]     elapsed_inc;
  logic [DLY_W-1:0]     delay_dec;
  logic [POS_W-1:0]     bit_pos;
  logic                 emit;

  // The queue only fills when the back end stalls; a beat is taken whenever a slot is free.
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && !q_full;

  assign elapsed_inc = (elapsed_r != '1) ? elapsed_r + GAP_W'(1) : elapsed_r;
  assign delay_dec   = (delay_cnt_r != '0) ? delay_cnt_r - DLY_W'(1) : '0;
  assign bit_pos     = POS_W'(WORD_BITS - 1) - bit_idx_r[POS_W-1:0];

  always_comb begin
    high_seen_nxt = high_seen_r;
    elapsed_nxt   = elapsed_r;
    delay_cnt_nxt = delay_cnt_r;
    awaiting_nxt  = awaiting_r;
    bit_idx_nxt   = bit_idx_r;
    word_nxt      = word_r;
    emit          = 1'b0;
    if (in_fire) begin
      elapsed_nxt = elapsed_inc;
      priority if (awaiting_r) begin
        delay_cnt_nxt = delay_dec;
        if (delay_dec == '0) begin
          awaiting_nxt = 1'b0;
          if (bit_idx_r < CNT_W'(WORD_BITS)) begin
            word_nxt[bit_pos] = !in_ch.data_level;
            bit_idx_nxt       = bit_idx_r + CNT_W'(1);
          end
        end
      end else if (in_ch.clock_level) begin
        high_seen_nxt = 1'b1;
      end else if (high_seen_r) begin
        // Falling edge: a long quiet gap closes the word before this bit.
        if (elapsed_inc > gap_r) begin
          emit        = 1'b1;
          bit_idx_nxt = '0;
        end
        elapsed_nxt   = '0;
        high_seen_nxt = 1'b0;
        delay_cnt_nxt = (sdelay_r != '0) ? sdelay_r : DLY_W'(1);
        awaiting_nxt  = 1'b1;
      end
    end
  end

  assign push.push        = emit;
  assign push.entry.word  = word_r;
  assign push.entry.count = bit_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= GAP_RESET;
      sdelay_r    <= DELAY_RESET;
      high_seen_r <= 1'b0;
      elapsed_r   <= '0;
      delay_cnt_r <= '0;
      awaiting_r  <= 1'b0;
      bit_idx_r   <= '0;
      word_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_GAP_TICKS:    gap_r    <= cfg_wdata[GAP_W-1:0];
          CFG_SAMPLE_DELAY: sdelay_r <= cfg_wdata[DLY_W-1:0];
          default:          ;
        endcase
      end
      high_seen_r <= high_seen_nxt;
      elapsed_r   <= elapsed_nxt;
      delay_cnt_r <= delay_cnt_nxt;
      awaiting_r  <= awaiting_nxt;
      bit_idx_r   <= bit_idx_nxt;
      word_r      <= word_nxt;
    end
  end

  a_bit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r <= CNT_W'(WORD_BITS))
    else $error("bit index ran past the word length");

  a_pending_has_delay: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (delay_cnt_r != '0))
    else $error("sample pending with an expired delay count");

endmodule

`default_nettype wire

// ===== src/cbws_queue.sv =====
`default_nettype none

module cbws_queue import cbws_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cbws_push_t push,
  input  wire logic       pop,
  output logic            full,
  output cbws_head_t      head
);

  cbws_word_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = slot_r[rd_ptr_r];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> !full)
    else $error("closed word pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// ===== src/cbws_back.sv =====
`default_nettype none

module cbws_back import cbws_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cbws_head_t head,
  output logic            pop,
  cbws_out_if.source      out_ch
);

  cbws_result_t         result_r;
  cbws_result_t         result_nxt;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] w;
  logic [7:0]           cmd;
  kind_t                kind;

  assign w   = head.entry.word;
  assign cmd = w[WORD_BITS-1 -: 8];

  always_comb begin
    unique case (cmd)
      CMD_LED:   kind = KIND_LED;
      CMD_DATE:  kind = KIND_DATE;
      CMD_ZONE0: kind = KIND_ZONE0;
      CMD_ZONE1: kind = KIND_ZONE1;
      CMD_ZONE2: kind = KIND_ZONE2;
      CMD_ZONE3: kind = KIND_ZONE3;
      default:   kind = KIND_UNKNOWN;
    endcase
  end

  // Every field comes from its fixed position whatever the kind.
  always_comb begin
    result_nxt.word_bits     = w;
    result_nxt.bits_received = head.entry.count;
    result_nxt.command       = cmd;
    result_nxt.kind          = kind;
    result_nxt.led_flags     = w[WORD_BITS-1-12 -: 5];
    result_nxt.year_tens     = w[WORD_BITS-1-9 -: 4];
    result_nxt.year_ones     = w[WORD_BITS-1-13 -: 4];
    result_nxt.month_value   = w[WORD_BITS-1-19 -: 4];
    result_nxt.day_value     = w[WORD_BITS-1-23 -: 5];
    result_nxt.hour_value    = w[WORD_BITS-1-28 -: 5];
    result_nxt.minute_value  = w[WORD_BITS-1-33 -: 6];
    result_nxt.zone_mask     = w[WORD_BITS-1-41 -: 8];
  end

  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.word_bits     = result_r.word_bits;
  assign out_ch.bits_received = result_r.bits_received;
  assign out_ch.command       = result_r.command;
  assign out_ch.kind          = result_r.kind;
  assign out_ch.led_flags     = result_r.led_flags;
  assign out_ch.year_tens     = result_r.year_tens;
  assign out_ch.year_ones     = result_r.year_ones;
  assign out_ch.month_value   = result_r.month_value;
  assign out_ch.day_value     = result_r.day_value;
  assign out_ch.hour_value    = result_r.hour_value;
  assign out_ch.minute_value  = result_r.minute_value;
  assign out_ch.zone_mask     = result_r.zone_mask;

endmodule

`default_nettype wire

// ===== src/clocked_bus_word_sniffer.sv =====
// Serial bus word sniffer.
// in_ch carries one pin sample per beat (clock_level, data_level). A falling
// edge on the bus clock arms a data sample sample_delay beats later; the data
// pin is stored inverted as the next bit of the word. A falling edge that
// comes more than gap_ticks beats after the previous one closes the word, and
// out_ch then delivers it with its command byte, kind and fixed bit fields.
// The cfg_ port writes gap_ticks (index 0) and sample_delay (index 1); the
// user must write them only while the block is idle; the block itself does not
// enforce this. Throughput: one input beat per cycle while the queue is not
// full. A closed word reaches out_ch through a two-entry queue and the
// output register.
// When the receiver stalls, closed words wait in the output register and the
// queue; in_ch.ready drops only while the queue is full.
// Reset clears the edge tracker, counters and the stored word, and restores
// the register defaults (gap_ticks 110, sample_delay 5).
`default_nettype none

module clocked_bus_word_sniffer import cbws_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cbws_in_if.sink                    in_ch,
  cbws_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cbws_push_t push;
  cbws_head_t head;
  logic       q_full;
  logic       pop;

  cbws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push)
  );

  cbws_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  cbws_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
